FILE: hw/rtl/rwc_pkg.sv
// package for the replay window check: depth, widths and request codes
`timescale 1ns / 1ps

package rwc_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int TIME_W       = 32;
    localparam int SEQ_W        = 32;

    typedef logic [WINDOW_DEPTH-1:0] t_window;
    typedef logic [FILL_W-1:0]       t_fill;
    typedef logic [TIME_W-1:0]       t_time;
    typedef logic [SEQ_W-1:0]        t_seq;

    typedef enum logic {
        REQ_TEST = 1'b0,
        REQ_ADD  = 1'b1
    } t_req_type;

endpackage

FILE: hw/rtl/replay_window_check_top.sv
// anti-replay sliding window check: input register, one pass of logic, result register
`timescale 1ns / 1ps

// Usage
//   Input channel: i_valid / o_stall with i_req_type, i_packet_time, i_packet_seq.
//   req_type test asks whether a packet is fresh; req_type add records it as seen.
//   Output channel: o_valid / i_stall with o_verdict, one result for every item.
//   An item is taken at a rising edge with valid high and stall low.
// Flow and throughput
//   An item passes from the input register to the result register and o_valid.
//   One item per cycle is sustained while i_stall is low: the window state is read
//   and rewritten in the single logic pass between the input register and the
//   result register, so the next item sees the state the previous one left.
// Reset
//   i_rst_n low at a clock edge empties both registers, sets epoch and
//   highest id to zero and clears the window and its fill count.
// Stalls
//   While i_stall holds a result, the pass stage stops and o_stall rises
//   once the input register is full; nothing is lost or repeated.

module replay_window_check_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_req_type,
    input  rwc_pkg::t_time      i_packet_time,
    input  rwc_pkg::t_seq       i_packet_seq,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_verdict
);
    import rwc_pkg::*;

    localparam t_seq  DEPTH_SEQ  = SEQ_W'(WINDOW_DEPTH);
    localparam t_fill DEPTH_FILL = FILL_W'(WINDOW_DEPTH);

    // input register
    logic      r_in_valid;
    t_req_type r_in_req;
    t_time     r_in_time;
    t_seq      r_in_seq;

    // window state
    t_time   r_epoch_time;
    t_seq    r_highest_seq;
    t_window r_seen_bits;
    t_fill   r_fill_count;

    // result register
    logic r_out_valid;
    logic r_out_verdict;

    logic w_out_load;
    logic w_in_load;
    logic w_fire;

    // next state and verdict
    t_time   n_epoch_time;
    t_seq    n_highest_seq;
    t_window n_seen_bits;
    t_fill   n_fill_count;
    logic    n_verdict;

    // test path
    t_seq    w_test_d;
    logic    w_test_verdict;

    // add path
    logic            w_restart;
    t_time           w_e1;
    t_seq            w_hs1;
    t_window         w_bits1;
    t_fill           w_fill1;
    t_seq            w_diff;
    t_fill           w_k;
    logic [FILL_W:0] w_fill_sum;
    t_seq            w_hs2;
    t_window         w_bits2;
    t_fill           w_fill2;
    t_seq            w_add_d;
    logic            w_add_hit;

    assign w_out_load = !r_out_valid || !i_stall;
    assign w_fire     = r_in_valid && w_out_load;
    assign o_stall    = r_in_valid && !w_out_load;
    assign w_in_load  = !o_stall;

    // test rules
    always_comb begin
        w_test_d       = r_highest_seq - r_in_seq;
        w_test_verdict = 1'b0;
        if (r_in_seq == '0) begin
            w_test_verdict = 1'b0;
        end else if (r_in_time == r_epoch_time) begin
            if (r_in_seq > r_highest_seq) begin
                w_test_verdict = 1'b1;
            end else if (w_test_d < SEQ_W'(r_fill_count)) begin
                w_test_verdict = !r_seen_bits[w_test_d[IDX_W-1:0]];
            end else begin
                w_test_verdict = 1'b0;
            end
        end else begin
            w_test_verdict = (r_in_time > r_epoch_time);
        end
    end

    // add rules: restart, advance, mark
    always_comb begin
        w_restart = (r_fill_count == '0) || (r_in_time > r_epoch_time) ||
                    ((r_in_seq >= DEPTH_SEQ) && ((r_in_seq - DEPTH_SEQ) > r_highest_seq));
        if (w_restart) begin
            w_e1    = r_in_time;
            w_hs1   = (r_in_seq > DEPTH_SEQ) ? (r_in_seq - DEPTH_SEQ) : '0;
            w_bits1 = '0;
            w_fill1 = '0;
        end else begin
            w_e1    = r_epoch_time;
            w_hs1   = r_highest_seq;
            w_bits1 = r_seen_bits;
            w_fill1 = r_fill_count;
        end

        w_diff     = r_in_seq - w_hs1;
        w_k        = (w_diff > DEPTH_SEQ) ? DEPTH_FILL : w_diff[FILL_W-1:0];
        w_fill_sum = {1'b0, w_fill1} + {1'b0, w_k};

        if (r_in_seq > w_hs1) begin
            w_bits2 = w_bits1 << w_k;
            w_fill2 = (w_fill_sum > {1'b0, DEPTH_FILL}) ? DEPTH_FILL : w_fill_sum[FILL_W-1:0];
            w_hs2   = r_in_seq;
        end else begin
            w_bits2 = w_bits1;
            w_fill2 = w_fill1;
            w_hs2   = w_hs1;
        end

        w_add_d   = w_hs2 - r_in_seq;
        w_add_hit = (w_add_d < SEQ_W'(w_fill2));
    end

    always_comb begin
        n_epoch_time  = r_epoch_time;
        n_highest_seq = r_highest_seq;
        n_seen_bits   = r_seen_bits;
        n_fill_count  = r_fill_count;
        unique case (r_in_req)
            REQ_TEST: begin
                n_verdict = w_test_verdict;
            end
            REQ_ADD: begin
                n_epoch_time  = w_e1;
                n_highest_seq = w_hs2;
                n_fill_count  = w_fill2;
                n_seen_bits   = w_bits2;
                if (w_add_hit) begin
                    n_seen_bits[w_add_d[IDX_W-1:0]] = 1'b1;
                end
                n_verdict = w_add_hit;
            end
            default: begin
                n_verdict = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_valid) begin
            r_in_req  <= t_req_type'(i_req_type);
            r_in_time <= i_packet_time;
            r_in_seq  <= i_packet_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_time  <= '0;
            r_highest_seq <= '0;
            r_seen_bits   <= '0;
            r_fill_count  <= '0;
        end else if (w_fire) begin
            r_epoch_time  <= n_epoch_time;
            r_highest_seq <= n_highest_seq;
            r_seen_bits   <= n_seen_bits;
            r_fill_count  <= n_fill_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_verdict <= n_verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;

    // fill count never passes the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= DEPTH_FILL)
        else $error("fill count above window depth");

    // no mark lies beyond the filled part of the window
    a_marks_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen_bits >> r_fill_count) == '0)
        else $error("window mark outside filled depth");

    // an item leaving the pass stage shows up as a result
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed item produced no result");

    // a stalled item stays in the input register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_load) |=> r_in_valid)
        else $error("stalled item lost from input register");

endmodule

FILE: sim/tb_replay_window_check_top.sv
// testbench for replay_window_check_top: directed and random packets against a window predictor
`timescale 1ns / 1ps

module tb_replay_window_check_top;
    import rwc_pkg::*;

    typedef struct {
        t_req_type req;
        t_time     stamp;
        t_seq      id;
        bit        drain_first;
    } t_packet;

    typedef struct {
        t_req_type req;
        t_time     stamp;
        t_seq      id;
        logic      verdict;
        int        idx;
    } t_due;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_stall;
    logic   i_req_type = REQ_TEST;
    t_time  i_packet_time = '0;
    t_seq   i_packet_seq = '0;
    logic   o_valid;
    logic   i_stall = 1'b0;
    logic   o_verdict;

    t_packet packets_pending[$];
    t_due    verdicts_due[$];
    logic    verdicts_got[$];

    // predicted window state
    t_time       win_epoch = '0;
    t_seq        win_top_seq = '0;
    t_window     win_marks = '0;
    logic [31:0] win_fill = '0;

    int total_items = 0;
    int n_sent = 0;
    int n_seen = 0;
    int send_gap = 0;
    int stall_gap = 0;
    int fail_count = 0;

    replay_window_check_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_packet_time (i_packet_time),
        .i_packet_seq  (i_packet_seq),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_verdict     (o_verdict)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic window_verdict(input t_req_type req, input t_time stamp,
                                            input t_seq id);
        logic [31:0] d;
        logic [31:0] k;
        if (req == REQ_TEST) begin
            if (id == '0) return 1'b0;
            if (stamp != win_epoch) return stamp > win_epoch;
            if (id > win_top_seq) return 1'b1;
            d = win_top_seq - id;
            if (d >= win_fill) return 1'b0;
            return !win_marks[d[IDX_W-1:0]];
        end
        if (win_fill == 0 || stamp > win_epoch ||
            (id >= WINDOW_DEPTH && id - WINDOW_DEPTH > win_top_seq)) begin
            win_epoch   = stamp;
            win_top_seq = (id > WINDOW_DEPTH) ? id - WINDOW_DEPTH : '0;
            win_marks   = '0;
            win_fill    = '0;
        end
        if (id > win_top_seq) begin
            k = id - win_top_seq;
            if (k > WINDOW_DEPTH) k = WINDOW_DEPTH;
            win_marks   = (k >= WINDOW_DEPTH) ? '0 : win_marks << k;
            win_fill    = (win_fill + k > WINDOW_DEPTH) ? WINDOW_DEPTH : win_fill + k;
            win_top_seq = id;
        end
        d = win_top_seq - id;
        if (d < win_fill) begin
            win_marks[d[IDX_W-1:0]] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // idling stops in calm bands and near the end of the run
    function automatic bit no_idling(input int done);
        return (done + 100 >= total_items) || ((done / 60) % 4 == 3);
    endfunction

    task automatic add_packet(input t_req_type req, input t_time stamp, input t_seq id,
                              input bit drain_first);
        t_packet p;
        p.req         = req;
        p.stamp       = stamp;
        p.id          = id;
        p.drain_first = drain_first;
        packets_pending.push_back(p);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_packet p;
        t_due    e;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                e.req     = t_req_type'(i_req_type);
                e.stamp   = i_packet_time;
                e.id      = i_packet_seq;
                e.verdict = window_verdict(e.req, e.stamp, e.id);
                e.idx     = n_sent;
                verdicts_due.push_back(e);
                n_sent++;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (packets_pending.size() == 0 ||
                         (packets_pending[0].drain_first && verdicts_due.size() != 0)) begin
                i_valid <= 1'b0;
            end else if (!no_idling(n_sent) && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 7) - 1;
                i_valid <= 1'b0;
            end else begin
                p = packets_pending.pop_front();
                i_req_type    <= p.req;
                i_packet_time <= p.stamp;
                i_packet_seq  <= p.id;
                i_valid       <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_gap = 0;
        end else begin
            if (o_valid && !i_stall) begin
                verdicts_got.push_back(o_verdict);
                n_seen++;
            end
            if (stall_gap > 0) begin
                stall_gap--;
                i_stall <= 1'b1;
            end else if (!no_idling(n_seen) && $urandom_range(0, 7) == 0) begin
                stall_gap = $urandom_range(1, 7) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        logic got;
        t_due e;
        while (verdicts_got.size() != 0) begin
            got = verdicts_got.pop_front();
            if (verdicts_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected verdict %b with no item outstanding", got);
            end else begin
                e = verdicts_due.pop_front();
                if (got !== e.verdict) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("item %0d %s time %h seq %h: expected %b got %b",
                                 e.idx, e.req.name(), e.stamp, e.id, e.verdict, got);
                end
            end
        end
    end

    initial begin
        t_time gen_time;
        t_seq  gen_seq;
        int    r;
        int    jit;
        bit    drain;

        // directed
        add_packet(REQ_TEST, 32'd0, 32'd0, 1'b0);
        add_packet(REQ_TEST, 32'd0, 32'd5, 1'b0);
        add_packet(REQ_ADD, 32'd0, 32'd0, 1'b0);
        add_packet(REQ_ADD, 32'd10, 32'd100, 1'b0);
        add_packet(REQ_TEST, 32'd10, 32'd100, 1'b0);
        add_packet(REQ_TEST, 32'd10, 32'd99, 1'b0);
        add_packet(REQ_ADD, 32'd10, 32'd99, 1'b0);
        add_packet(REQ_TEST, 32'd10, 32'd99, 1'b0);
        add_packet(REQ_ADD, 32'd10, 32'd36, 1'b0);
        add_packet(REQ_TEST, 32'd10, 32'd37, 1'b0);
        add_packet(REQ_TEST, 32'd9, 32'd200, 1'b0);
        add_packet(REQ_TEST, 32'd11, 32'd1, 1'b0);
        add_packet(REQ_ADD, 32'd10, 32'd103, 1'b0);
        add_packet(REQ_ADD, 32'd10, 32'd300, 1'b0);
        add_packet(REQ_ADD, 32'd5, 32'd301, 1'b0);
        add_packet(REQ_ADD, 32'd5, 32'd290, 1'b0);
        add_packet(REQ_TEST, 32'd10, 32'd290, 1'b0);
        add_packet(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_packet(REQ_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_packet(REQ_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        add_packet(REQ_ADD, 32'hFFFF_FFFF, 32'd64, 1'b0);
        add_packet(REQ_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFBF, 1'b0);
        add_packet(REQ_ADD, 32'hFFFF_FFFF, 32'd1, 1'b0);
        add_packet(REQ_ADD, 32'd20, 32'd64, 1'b0);

        // random, mostly runs of adds and tests around a moving window
        gen_time = 32'd1000;
        gen_seq  = 32'd500;
        for (int n = 0; n < 750; n++) begin
            r     = $urandom_range(0, 99);
            jit   = $urandom_range(0, 70);
            drain = (n == 0 || n == 300 || n == 550);
            if (r < 40) begin
                if ($urandom_range(0, 3) == 0) begin
                    add_packet(REQ_ADD, gen_time, gen_seq - jit, drain);
                end else begin
                    gen_seq += $urandom_range(0, 4);
                    add_packet(REQ_ADD, gen_time, gen_seq, drain);
                end
            end else if (r < 75) begin
                add_packet(REQ_TEST, gen_time, gen_seq + 2 - jit, drain);
            end else if (r < 80) begin
                gen_time += $urandom_range(1, 3);
                add_packet(REQ_ADD, gen_time, gen_seq, drain);
            end else if (r < 85) begin
                gen_seq += $urandom_range(60, 200);
                add_packet(REQ_ADD, gen_time, gen_seq, drain);
            end else if (r < 89) begin
                add_packet(t_req_type'($urandom_range(0, 1)),
                           gen_time - $urandom_range(1, 3), gen_seq - jit, drain);
            end else if (r < 91) begin
                add_packet(t_req_type'($urandom_range(0, 1)), gen_time, '0, drain);
            end else if (r < 95) begin
                add_packet(t_req_type'($urandom_range(0, 1)), $urandom, $urandom, drain);
            end else begin
                gen_time = $urandom;
                gen_seq  = ($urandom_range(0, 1) == 0) ? t_seq'($urandom)
                                                        : t_seq'($urandom_range(0, 130));
                add_packet(REQ_ADD, gen_time, gen_seq, drain);
            end
        end
        total_items = packets_pending.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (packets_pending.size() != 0 || i_valid || verdicts_due.size() != 0 ||
               verdicts_got.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_count == 0 && verdicts_due.size() == 0) begin
            $display("replay_window_check_top: match");
        end else begin
            $display("replay_window_check_top: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("replay_window_check_top: mismatch");
        $finish;
    end

endmodule

FILE: replay_window_check_top.f
hw/rtl/rwc_pkg.sv
hw/rtl/replay_window_check_top.sv
sim/tb_replay_window_check_top.sv
